@@ hw/rtl/vtd_pkg.sv @@
// Shared types, constants and helpers of the Viterbi tag decoder.
// Used by vtd_acs and viterbi_tag_decoder; depends on nothing else.
package vtd_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_STATES_DEF = 32;
	localparam int MAX_VOCAB_DEF  = 1024;
	localparam int MAX_LEN_DEF    = 64;

	// Fixed field widths of the stream and register interfaces.
	localparam int TAG_W   = 5;
	localparam int SCORE_W = 24;
	localparam int POS_W   = 6;
	localparam int TOKEN_W = 12;
	localparam int TVAL_W  = 16;
	localparam int CAND_W  = 26;

	// Register indexes on the configuration port.
	localparam logic REG_NUM_STATES = 1'b0;
	localparam logic REG_VOCAB_SIZE = 1'b1;

	// Score floor of -100.0 in Q16.8.
	localparam logic signed [CAND_W-1:0] SCORE_FLOOR = -26'sd25600;
	localparam logic signed [CAND_W-1:0] SAT_HI = 26'sd8388607;
	localparam logic signed [CAND_W-1:0] SAT_LO = -26'sd8388608;

	// Request kinds carried in the input tuser.
	typedef enum logic [1:0] {
		REQ_LOAD_TRANS = 2'd0,
		REQ_LOAD_EMIS  = 2'd1,
		REQ_DECODE     = 2'd2,
		REQ_UNUSED     = 2'd3
	} req_type_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FWD,
		ST_DRAIN,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_FIN_OUT,
		ST_BT_BP,
		ST_BT_SC,
		ST_BT_OUT,
		ST_ERR_OUT
	} state_t;

	// Tags that travel with one add-compare read through the pipeline.
	typedef struct packed {
		logic valid;
		logic first_i;
		logic last_i;
		logic pos0;
	} acs_ctrl_t;

	// Saturate a candidate score to the stored Q16.8 range.
	function automatic logic signed [SCORE_W-1:0] sat24(input logic signed [CAND_W-1:0] v);
		logic signed [SCORE_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SCORE_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SCORE_W-1:0];
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/vtd_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
module vtd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/vtd_acs.sv @@
// Add-compare-select pipeline of the forward pass.
// Depends on vtd_pkg; fed by the score, transition and emission RAMs.
module vtd_acs #(
	parameter int MAX_STATES = vtd_pkg::MAX_STATES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vtd_pkg::acs_ctrl_t                    ctrl,
	input  logic [$clog2(MAX_STATES)-1:0]         i_idx,
	input  logic [$clog2(MAX_STATES)-1:0]         j_idx,
	input  logic signed [vtd_pkg::SCORE_W-1:0]    score_rd,
	input  logic signed [vtd_pkg::TVAL_W-1:0]     trans_rd,
	input  logic signed [vtd_pkg::TVAL_W-1:0]     emis_rd,
	output logic                                  wr_en,
	output logic [$clog2(MAX_STATES)-1:0]         wr_j,
	output logic signed [vtd_pkg::SCORE_W-1:0]    wr_score,
	output logic [$clog2(MAX_STATES)-1:0]         wr_bp,
	output logic                                  busy
);

	localparam int SW = $clog2(MAX_STATES);

	vtd_pkg::acs_ctrl_t                   ctrl_s1, ctrl_s2;
	logic [SW-1:0]                        i_s1, j_s1, i_s2, j_s2;
	logic signed [vtd_pkg::CAND_W-1:0]    cand, cand_s2;
	logic signed [vtd_pkg::CAND_W-1:0]    best_q, cur_best, new_best;
	logic [SW-1:0]                        arg_q, cur_arg, new_arg;

	// Tags are registered in step with the RAM reads, then registered again in step with the sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		i_s1    <= i_idx;
		j_s1    <= j_idx;
		i_s2    <= i_s1;
		j_s2    <= j_s1;
		cand_s2 <= cand;
	end

	// Candidate: previous score plus transition plus emission; position 0 takes emission alone.
	always_comb begin
		if (ctrl_s1.pos0) begin
			cand = vtd_pkg::CAND_W'(emis_rd);
		end else begin
			cand = vtd_pkg::CAND_W'(score_rd) + vtd_pkg::CAND_W'(trans_rd)
				+ vtd_pkg::CAND_W'(emis_rd);
		end
	end

	// Strictly-greater compare against the running best, which starts at the floor.
	always_comb begin
		cur_best = ctrl_s2.first_i ? vtd_pkg::SCORE_FLOOR : best_q;
		cur_arg  = ctrl_s2.first_i ? '0 : arg_q;
		if (ctrl_s2.pos0) begin
			new_best = cand_s2;
			new_arg  = '0;
		end else if (cand_s2 > cur_best) begin
			new_best = cand_s2;
			new_arg  = i_s2;
		end else begin
			new_best = cur_best;
			new_arg  = cur_arg;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			best_q <= new_best;
			arg_q  <= new_arg;
		end
	end

	// The winner of a destination state is written after its last source.
	assign wr_en    = ctrl_s2.valid & ctrl_s2.last_i;
	assign wr_j     = j_s2;
	assign wr_score = vtd_pkg::sat24(new_best);
	assign wr_bp    = new_arg;
	assign busy     = ctrl_s1.valid | ctrl_s2.valid;

endmodule

@@ hw/rtl/viterbi_tag_decoder.sv @@
// Viterbi tag decoder: top level with the request sequencer, register port and RAMs.
// Depends on vtd_pkg, vtd_ram and vtd_acs.
//
// Loads (tuser 0 or 1) write a transition or emission entry. A decode token runs
// one add-compare per source and destination state pair through the score,
// transition and emission RAMs, one pair per cycle; at the first position only
// one add-compare per destination state runs. On the last token the block scans
// the final row and then backtracks one result at a time: backpointer read,
// dependent score read, then output once the result register is free. Results leave
// from the last position down to position 0; an invalid token or an overlong
// sequence gives one error result at the end of the run. New requests are taken
// only while no token or backtrack is in progress. The tables and score stores
// have no reset; every entry used must have been loaded first.
module viterbi_tag_decoder #(
	parameter int MAX_STATES = vtd_pkg::MAX_STATES_DEF,
	parameter int MAX_VOCAB  = vtd_pkg::MAX_VOCAB_DEF,
	parameter int MAX_LEN    = vtd_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // from_state[4:0], to_state[9:5], token[21:10], table_value[37:22]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	input  logic        s_tlast,  // last_token
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // tag[4:0], path_score[28:5], position[34:29]
	output logic [0:0]  m_tuser,  // error[0]
	output logic        m_tlast   // last
);

	localparam int SW    = $clog2(MAX_STATES);
	localparam int PW    = $clog2(MAX_LEN + 1);
	localparam int TW    = $clog2(MAX_VOCAB);
	localparam int TR_D  = MAX_STATES * MAX_STATES;
	localparam int EM_D  = MAX_VOCAB * MAX_STATES;
	localparam int SC_D  = MAX_LEN * MAX_STATES;
	localparam int TR_AW = $clog2(TR_D);
	localparam int EM_AW = $clog2(EM_D);
	localparam int SC_AW = $clog2(SC_D);

	// Request fields
	logic [4:0]                              in_from, in_to;
	logic [vtd_pkg::TOKEN_W-1:0]             in_token;
	logic [vtd_pkg::TVAL_W-1:0]              in_value;
	vtd_pkg::req_type_t                      in_type;
	logic                                    s_acc;

	// Registers and control state
	logic [5:0]                              num_states_q;
	logic [10:0]                             vocab_size_q;
	vtd_pkg::state_t                         state_q, state_d;
	logic [SW-1:0]                           i_q, j_q, st_q, ns_last;
	logic [PW-1:0]                           pos_q, t_q;
	logic                                    err_q, last_q;
	logic [TW-1:0]                           tok_q;
	logic                                    bad_tok, pos0, i_last, j_last, out_free;

	// Scan of the final row
	logic                                    scan_v_s1, scan_first_s1;
	logic [SW-1:0]                           scan_j_s1;
	logic signed [vtd_pkg::CAND_W-1:0]       best_q, scan_cur;

	// RAM ports
	logic                                    tr_we, em_we, sc_re, bp_re, fwd_re;
	logic [TR_AW-1:0]                        tr_waddr, tr_raddr;
	logic [EM_AW-1:0]                        em_waddr, em_raddr;
	logic [SC_AW-1:0]                        sc_raddr, bp_raddr, wr_addr;
	logic signed [vtd_pkg::TVAL_W-1:0]       tr_rd, em_rd;
	logic signed [vtd_pkg::SCORE_W-1:0]      sc_rd, wr_score;
	logic [SW-1:0]                           bp_rd, wr_j, wr_bp;
	logic                                    wr_en, acs_busy;
	vtd_pkg::acs_ctrl_t                      acs_ctrl;

	// Result register
	logic                                    out_load, out_v_q;
	logic [vtd_pkg::TAG_W-1:0]               out_tag_d, out_tag_q;
	logic signed [vtd_pkg::SCORE_W-1:0]      out_score_d, out_score_q;
	logic [vtd_pkg::POS_W-1:0]               out_pos_d, out_pos_q;
	logic                                    out_err_d, out_err_q, out_last_d, out_last_q;

	assign in_from  = s_tdata[4:0];
	assign in_to    = s_tdata[9:5];
	assign in_token = s_tdata[21:10];
	assign in_value = s_tdata[37:22];
	assign in_type  = vtd_pkg::req_type_t'(s_tuser);
	assign s_tready = (state_q == vtd_pkg::ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;

	// Register port: writes on the access cycle, reads return the stored value.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= 6'd1;
			vocab_size_q <= 11'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				vtd_pkg::REG_NUM_STATES: num_states_q <= pwdata[5:0];
				vtd_pkg::REG_VOCAB_SIZE: vocab_size_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			vtd_pkg::REG_NUM_STATES: prdata = {26'd0, num_states_q};
			vtd_pkg::REG_VOCAB_SIZE: prdata = {21'd0, vocab_size_q};
			default:                 prdata = '0;
		endcase
	end

	// Effective state count and token validity.
	always_comb begin
		if (num_states_q == 6'd0) begin
			ns_last = '0;
		end else if (int'(num_states_q) > MAX_STATES) begin
			ns_last = SW'(MAX_STATES - 1);
		end else begin
			ns_last = SW'(int'(num_states_q) - 1);
		end
	end

	always_comb begin
		if (int'(vocab_size_q) > MAX_VOCAB) begin
			bad_tok = int'(in_token) >= MAX_VOCAB;
		end else begin
			bad_tok = int'(in_token) >= int'(vocab_size_q);
		end
	end

	assign pos0     = (pos_q == '0);
	assign i_last   = pos0 || (i_q == ns_last);
	assign j_last   = (j_q == ns_last);
	assign out_free = !out_v_q || m_tready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			vtd_pkg::ST_IDLE: begin
				if (s_acc && in_type == vtd_pkg::REQ_DECODE) begin
					if (!err_q && !bad_tok && int'(pos_q) < MAX_LEN) begin
						state_d = vtd_pkg::ST_FWD;
					end else if (s_tlast) begin
						state_d = vtd_pkg::ST_ERR_OUT;
					end
				end
			end
			vtd_pkg::ST_FWD: begin
				if (i_last && j_last) begin
					state_d = vtd_pkg::ST_DRAIN;
				end
			end
			vtd_pkg::ST_DRAIN: begin
				if (!acs_busy) begin
					state_d = last_q ? vtd_pkg::ST_SCAN : vtd_pkg::ST_IDLE;
				end
			end
			vtd_pkg::ST_SCAN: begin
				if (j_last) begin
					state_d = vtd_pkg::ST_SCAN_WAIT;
				end
			end
			vtd_pkg::ST_SCAN_WAIT: state_d = vtd_pkg::ST_FIN_OUT;
			vtd_pkg::ST_FIN_OUT: begin
				if (out_free) begin
					state_d = (pos_q == PW'(1)) ? vtd_pkg::ST_IDLE : vtd_pkg::ST_BT_BP;
				end
			end
			vtd_pkg::ST_BT_BP: state_d = vtd_pkg::ST_BT_SC;
			vtd_pkg::ST_BT_SC: state_d = vtd_pkg::ST_BT_OUT;
			vtd_pkg::ST_BT_OUT: begin
				if (out_free) begin
					state_d = (t_q == PW'(1)) ? vtd_pkg::ST_IDLE : vtd_pkg::ST_BT_BP;
				end
			end
			vtd_pkg::ST_ERR_OUT: begin
				if (out_free) begin
					state_d = vtd_pkg::ST_IDLE;
				end
			end
			default: state_d = vtd_pkg::ST_IDLE;
		endcase
	end

	// Output logic: RAM reads, pipeline tags and result selection.
	always_comb begin
		fwd_re      = (state_q == vtd_pkg::ST_FWD);
		sc_re       = 1'b0;
		sc_raddr    = SC_AW'((int'(pos_q) - 1) * MAX_STATES + int'(i_q));
		bp_re       = (state_q == vtd_pkg::ST_BT_BP);
		bp_raddr    = SC_AW'(int'(t_q) * MAX_STATES + int'(st_q));
		acs_ctrl    = '0;
		out_load    = 1'b0;
		out_tag_d   = vtd_pkg::TAG_W'(st_q);
		out_score_d = best_q[vtd_pkg::SCORE_W-1:0];
		out_pos_d   = vtd_pkg::POS_W'(pos_q - PW'(1));
		out_err_d   = 1'b0;
		out_last_d  = (pos_q == PW'(1));
		case (state_q)
			vtd_pkg::ST_FWD: begin
				sc_re            = 1'b1;
				acs_ctrl.valid   = 1'b1;
				acs_ctrl.first_i = (i_q == '0);
				acs_ctrl.last_i  = i_last;
				acs_ctrl.pos0    = pos0;
			end
			vtd_pkg::ST_SCAN: begin
				sc_re    = 1'b1;
				sc_raddr = SC_AW'((int'(pos_q) - 1) * MAX_STATES + int'(j_q));
			end
			vtd_pkg::ST_BT_SC: begin
				sc_re    = 1'b1;
				sc_raddr = SC_AW'((int'(t_q) - 1) * MAX_STATES + int'(bp_rd));
			end
			vtd_pkg::ST_FIN_OUT: out_load = out_free;
			vtd_pkg::ST_BT_OUT: begin
				out_load    = out_free;
				out_score_d = sc_rd;
				out_pos_d   = vtd_pkg::POS_W'(t_q - PW'(1));
				out_last_d  = (t_q == PW'(1));
			end
			vtd_pkg::ST_ERR_OUT: begin
				out_load    = out_free;
				out_tag_d   = '0;
				out_score_d = '0;
				out_pos_d   = '0;
				out_err_d   = 1'b1;
				out_last_d  = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer state and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtd_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			pos_q   <= '0;
			t_q     <= '0;
			err_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				vtd_pkg::ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					if (s_acc && in_type == vtd_pkg::REQ_DECODE) begin
						last_q <= s_tlast;
						if (!err_q && (bad_tok || int'(pos_q) >= MAX_LEN)) begin
							err_q <= 1'b1;
						end
					end
				end
				vtd_pkg::ST_FWD: begin
					if (i_last) begin
						i_q <= '0;
						j_q <= j_q + SW'(1);
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				vtd_pkg::ST_DRAIN: begin
					j_q <= '0;
					if (!acs_busy) begin
						pos_q <= pos_q + PW'(1);
					end
				end
				vtd_pkg::ST_SCAN: j_q <= j_q + SW'(1);
				vtd_pkg::ST_FIN_OUT: begin
					if (out_free) begin
						t_q <= pos_q - PW'(1);
						if (pos_q == PW'(1)) begin
							pos_q <= '0;
							err_q <= 1'b0;
						end
					end
				end
				vtd_pkg::ST_BT_OUT: begin
					if (out_free) begin
						t_q <= t_q - PW'(1);
						if (t_q == PW'(1)) begin
							pos_q <= '0;
							err_q <= 1'b0;
						end
					end
				end
				vtd_pkg::ST_ERR_OUT: begin
					if (out_free) begin
						pos_q <= '0;
						err_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Token of the current decode request and backtrack state.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			tok_q <= TW'(in_token);
		end
		if (state_q == vtd_pkg::ST_BT_SC) begin
			st_q <= bp_rd;
		end else if (scan_v_s1) begin
			if (scan_first_s1 || sc_rd > scan_cur) begin
				st_q <= (sc_rd > scan_cur) ? scan_j_s1 : '0;
			end
		end
	end

	// Best final state: scan the last row, strictly greater, floor as the start.
	assign scan_cur = scan_first_s1 ? vtd_pkg::SCORE_FLOOR : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == vtd_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		scan_j_s1     <= j_q;
		scan_first_s1 <= (j_q == '0);
		if (scan_v_s1) begin
			best_q <= (vtd_pkg::CAND_W'(sc_rd) > scan_cur) ? vtd_pkg::CAND_W'(sc_rd) : scan_cur;
		end
	end

	// Result register with its handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_tag_q   <= out_tag_d;
			out_score_q <= out_score_d;
			out_pos_q   <= out_pos_d;
			out_err_q   <= out_err_d;
			out_last_q  <= out_last_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_pos_q, out_score_q, out_tag_q};
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

	// Table loads; entries outside the MAX_STATES and MAX_VOCAB bounds are dropped.
	assign tr_we    = s_acc && in_type == vtd_pkg::REQ_LOAD_TRANS
		&& int'(in_from) < MAX_STATES && int'(in_to) < MAX_STATES;
	assign em_we    = s_acc && in_type == vtd_pkg::REQ_LOAD_EMIS
		&& int'(in_from) < MAX_STATES && int'(in_token) < MAX_VOCAB;
	assign tr_waddr = TR_AW'(int'(in_from) * MAX_STATES + int'(in_to));
	assign em_waddr = EM_AW'(int'(in_token) * MAX_STATES + int'(in_from));
	assign tr_raddr = TR_AW'(int'(i_q) * MAX_STATES + int'(j_q));
	assign em_raddr = EM_AW'(int'(tok_q) * MAX_STATES + int'(j_q));
	assign wr_addr  = SC_AW'(int'(pos_q) * MAX_STATES + int'(wr_j));

	vtd_ram #(.WIDTH(vtd_pkg::TVAL_W), .DEPTH(TR_D)) u_trans_ram (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(in_value),
		.re(fwd_re), .raddr(tr_raddr), .rdata(tr_rd)
	);

	vtd_ram #(.WIDTH(vtd_pkg::TVAL_W), .DEPTH(EM_D)) u_emis_ram (
		.clk(clk), .we(em_we), .waddr(em_waddr), .wdata(in_value),
		.re(fwd_re), .raddr(em_raddr), .rdata(em_rd)
	);

	vtd_ram #(.WIDTH(vtd_pkg::SCORE_W), .DEPTH(SC_D)) u_score_ram (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_score),
		.re(sc_re), .raddr(sc_raddr), .rdata(sc_rd)
	);

	vtd_ram #(.WIDTH(SW), .DEPTH(SC_D)) u_bp_ram (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_bp),
		.re(bp_re), .raddr(bp_raddr), .rdata(bp_rd)
	);

	vtd_acs #(.MAX_STATES(MAX_STATES)) u_acs (
		.clk(clk), .arst_n(arst_n), .ctrl(acs_ctrl), .i_idx(i_q), .j_idx(j_q),
		.score_rd(sc_rd), .trans_rd(tr_rd), .emis_rd(em_rd),
		.wr_en(wr_en), .wr_j(wr_j), .wr_score(wr_score), .wr_bp(wr_bp),
		.busy(acs_busy)
	);

endmodule
